### rtl/core/lmsf_pkg.sv
// Shared constants, codes and control types of the LED matrix frame store.
`timescale 1ns / 1ps

package lmsf_pkg;

    // Panel geometry
    localparam int COLUMNS   = 32;
    localparam int SECTIONS  = 8;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int SEC_W     = $clog2(SECTIONS);
    localparam int PLANE_AW  = SEC_W + COL_W;
    localparam int PLANE     = 1 << PLANE_AW;
    localparam int MEM_AW    = PLANE_AW + 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;

    // Field widths
    localparam int RGB_W   = 3;
    localparam int ENTRY_W = 2 * RGB_W;
    localparam int ROW_W   = 4;
    localparam int CIN_W   = 5;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_READ    = 3'd1,
        OP_FILL    = 3'd2,
        OP_SWAP    = 3'd3,
        OP_COPY    = 3'd4,
        OP_REFRESH = 3'd5,
        OP_BLANK   = 3'd6,
        OP_UNBLANK = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_LATCH  = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_FILL,
        ST_COPY,
        ST_SHIFT,
        ST_LATCH,
        ST_STATUS
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic clear;
        logic write;
        logic read_out;
        logic fill;
        logic copy;
        logic shift;
        logic latch_out;
        logic status_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic fill_last;
        logic copy_last;
        logic shift_done;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/led_matrix_scan_framebuffer.sv
// Top level of the double-buffered LED matrix frame store with section scan.
`timescale 1ns / 1ps

// Double-buffered 16x32 RGB frame store for a 1/8-scan panel. Items are taken one at a
// time; the memory has one write and one registered read port, which sets the timing.
// A swap stays in idle; a pixel write or read, a blank and an unblank each go through
// their own state. Fill writes one entry a cycle over the back buffer; copy reads front
// and writes back in the following cycle; refresh issues 32 column reads, drains the last,
// sees the sweep end and sends the latch beat. Read, blank, unblank and refresh are
// stretched by output back-pressure. After reset a clearing pass writes all 512 entries
// to zero, one per cycle, and s_tready stays low until it ends.
module led_matrix_scan_framebuffer
    import lmsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // operation[2:0], row[6:3], column[11:7], color[14:12]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // color_bits[5:0], row_address[8:6], output_blanked[9]
    output logic [1:0]  o_m_tuser,   // kind[1:0]
    output logic        o_m_tlast
);

    t_op                w_op;
    t_cmd               w_cmd;
    t_stat              w_stat;
    logic [ENTRY_W-1:0] w_bits;
    logic [SEC_W-1:0]   w_addr;
    logic               w_blanked;

    assign w_op = t_op'(i_s_tdata[2:0]);

    lmsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (w_op),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    lmsf_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_op            (w_op),
        .i_row           (i_s_tdata[6:3]),
        .i_column        (i_s_tdata[11:7]),
        .i_color         (i_s_tdata[14:12]),
        .i_m_tready      (i_m_tready),
        .o_stat          (w_stat),
        .o_m_tvalid      (o_m_tvalid),
        .o_m_kind        (o_m_tuser),
        .o_m_color_bits  (w_bits),
        .o_m_row_address (w_addr),
        .o_m_blanked     (w_blanked),
        .o_m_last        (o_m_tlast)
    );

    // Pack the result beat
    assign o_m_tdata = {6'd0, w_blanked, w_addr, w_bits};

endmodule

### rtl/core/lmsf_ctrl.sv
// Sequencing state machine of the LED matrix frame store.
`timescale 1ns / 1ps

module lmsf_ctrl
    import lmsf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  t_op   i_op,
    input  t_stat i_stat,
    output logic  o_s_tready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    case (i_op)
                        OP_WRITE:   n_state = ST_WRITE;
                        OP_READ:    n_state = ST_READ;
                        OP_FILL:    n_state = ST_FILL;
                        OP_SWAP:    n_state = ST_IDLE;
                        OP_COPY:    n_state = ST_COPY;
                        OP_REFRESH: n_state = ST_SHIFT;
                        OP_BLANK:   n_state = ST_STATUS;
                        OP_UNBLANK: n_state = ST_STATUS;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_READ: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            ST_FILL: begin
                if (i_stat.fill_last) n_state = ST_IDLE;
            end
            ST_COPY: begin
                if (i_stat.copy_last) n_state = ST_IDLE;
            end
            ST_SHIFT: begin
                if (i_stat.shift_done) n_state = ST_LATCH;
            end
            ST_LATCH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            ST_STATUS: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR:  o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            ST_WRITE:  o_cmd.write      = 1'b1;
            ST_READ:   o_cmd.read_out   = 1'b1;
            ST_FILL:   o_cmd.fill       = 1'b1;
            ST_COPY:   o_cmd.copy       = 1'b1;
            ST_SHIFT:  o_cmd.shift      = 1'b1;
            ST_LATCH:  o_cmd.latch_out  = 1'b1;
            ST_STATUS: o_cmd.status_out = 1'b1;
            default:   o_cmd            = '0;
        endcase
    end

endmodule

### rtl/core/lmsf_datapath.sv
// Frame memory, scan registers and result register of the LED matrix frame store.
`timescale 1ns / 1ps

module lmsf_datapath
    import lmsf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_op                i_op,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [CIN_W-1:0]   i_column,
    input  logic [RGB_W-1:0]   i_color,
    input  logic               i_m_tready,
    output t_stat              o_stat,
    output logic               o_m_tvalid,
    output logic [1:0]         o_m_kind,
    output logic [ENTRY_W-1:0] o_m_color_bits,
    output logic [SEC_W-1:0]   o_m_row_address,
    output logic               o_m_blanked,
    output logic               o_m_last
);

    logic [ENTRY_W-1:0] r_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    logic               r_front;
    logic [SEC_W-1:0]   r_sec;
    logic               r_blank;
    logic [MEM_AW-1:0]  r_idx;
    logic [PLANE_AW-1:0] r_prev;
    logic               r_pend;

    logic [ROW_W-1:0]   r_row;
    logic [CIN_W-1:0]   r_col;
    logic [RGB_W-1:0]   r_color;

    logic               r_m_valid;
    t_kind              r_kind;
    logic [ENTRY_W-1:0] r_bits;
    logic [SEC_W-1:0]   r_addr;
    logic               r_blanked;
    logic               r_last;

    logic               out_free;
    logic               wr_en;
    logic [MEM_AW-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [MEM_AW-1:0]  rd_addr;
    logic               shift_issue;
    logic               shift_load;
    logic               load;
    t_kind              n_kind;
    logic [ENTRY_W-1:0] n_bits;
    logic [SEC_W-1:0]   n_addr;
    logic               n_blanked;
    logic               n_last;
    logic               col_ok;
    logic [RGB_W-1:0]   pix;
    logic [MEM_AW-1:0]  pix_addr;

    assign out_free = !r_m_valid || i_m_tready;
    assign col_ok   = int'(r_col) < COLUMNS;
    assign pix      = r_row[SEC_W] ? r_rd_data[ENTRY_W-1:RGB_W] : r_rd_data[RGB_W-1:0];
    assign pix_addr = {~r_front, r_row[SEC_W-1:0], COL_W'(r_col)};

    // Refresh column pipeline: one read in flight, drained into the result register
    assign shift_load  = i_cmd.shift && r_pend && out_free;
    assign shift_issue = i_cmd.shift && (r_idx < MEM_AW'(COLUMNS)) && (!r_pend || out_free);

    // Status toward the controller
    always_comb begin
        o_stat.clear_last = r_idx == MEM_AW'(MEM_DEPTH - 1);
        o_stat.fill_last  = r_idx[PLANE_AW-1:0] == PLANE_AW'(PLANE - 1);
        o_stat.copy_last  = r_idx[PLANE_AW];
        o_stat.shift_done = (r_idx == MEM_AW'(COLUMNS)) && !r_pend;
        o_stat.out_free   = out_free;
    end

    // Select the write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        if (i_cmd.clear) begin
            wr_en = 1'b1;
        end else if (i_cmd.fill) begin
            wr_en   = 1'b1;
            wr_addr = {~r_front, r_idx[PLANE_AW-1:0]};
            wr_data = {r_color, r_color};
        end else if (i_cmd.copy) begin
            wr_en   = r_idx != '0;
            wr_addr = {~r_front, r_prev};
            wr_data = r_rd_data;
        end else if (i_cmd.write) begin
            wr_en   = col_ok;
            wr_addr = pix_addr;
            wr_data = r_row[SEC_W] ? {r_color, r_rd_data[RGB_W-1:0]}
                                   : {r_rd_data[ENTRY_W-1:RGB_W], r_color};
        end
    end

    // Select the read port
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {~r_front, i_row[SEC_W-1:0], COL_W'(i_column)};
        if (i_cmd.accept && (i_op == OP_WRITE || i_op == OP_READ)) begin
            rd_en = 1'b1;
        end else if (i_cmd.copy) begin
            rd_en   = !r_idx[PLANE_AW];
            rd_addr = {r_front, r_idx[PLANE_AW-1:0]};
        end else if (shift_issue) begin
            rd_en   = 1'b1;
            rd_addr = {r_front, r_sec, r_idx[COL_W-1:0]};
        end
    end

    // Frame memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Capture the item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_row   <= i_row;
            r_col   <= i_column;
            r_color <= i_color;
        end
        r_prev <= r_idx[PLANE_AW-1:0];
    end

    // Panel state, sweep index and pending read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= 1'b0;
            r_sec   <= '0;
            r_blank <= 1'b1;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
                if (i_op == OP_SWAP)    r_front <= ~r_front;
                if (i_op == OP_BLANK)   r_blank <= 1'b1;
                if (i_op == OP_UNBLANK) r_blank <= 1'b0;
            end else if (i_cmd.clear || i_cmd.fill || i_cmd.copy || shift_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (shift_issue) begin
                r_pend <= 1'b1;
            end else if (shift_load) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.latch_out && out_free) begin
                r_blank <= 1'b0;
                r_sec   <= r_sec + 1'b1;
            end
        end
    end

    // Build the next result
    always_comb begin
        load      = shift_load
                  || ((i_cmd.read_out || i_cmd.latch_out || i_cmd.status_out) && out_free);
        n_kind    = KIND_STATUS;
        n_bits    = '0;
        n_addr    = '0;
        n_blanked = r_blank;
        n_last    = 1'b1;
        if (i_cmd.read_out) begin
            n_kind = KIND_READ;
            n_bits = col_ok ? {{(ENTRY_W - RGB_W){1'b0}}, pix} : '0;
        end else if (i_cmd.shift) begin
            n_kind = KIND_SHIFT;
            n_bits = r_rd_data;
            n_addr = r_sec;
            n_last = 1'b0;
        end else if (i_cmd.latch_out) begin
            n_kind    = KIND_LATCH;
            n_addr    = r_sec;
            n_blanked = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind    <= n_kind;
            r_bits    <= n_bits;
            r_addr    <= n_addr;
            r_blanked <= n_blanked;
            r_last    <= n_last;
        end
    end

    assign o_m_tvalid      = r_m_valid;
    assign o_m_kind        = r_kind;
    assign o_m_color_bits  = r_bits;
    assign o_m_row_address = r_addr;
    assign o_m_blanked     = r_blanked;
    assign o_m_last        = r_last;

endmodule

### rtl/core/lmsf_checker.sv
// Port-level checks of the LED matrix frame store, bound to the top level.
`timescale 1ns / 1ps

module lmsf_checker
    import lmsf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [15:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // Drop the result on reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled beat
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled beat changed");

    // A latch beat ends the refresh and shows the panel enabled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_LATCH |-> o_m_tlast && !o_m_tdata[9])
        else $error("latch beat malformed");

    // Column shift beats never end an item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_SHIFT |-> !o_m_tlast)
        else $error("shift beat marked last");

    // A pixel read occupies the block for its result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tdata[2:0] == OP_READ |=> !o_s_tready)
        else $error("ready stayed high after pixel read");

endmodule

bind led_matrix_scan_framebuffer lmsf_checker u_lmsf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

### verif/testbench.sv
// Self-checking stream testbench for the LED matrix frame store.
`timescale 1ns / 1ps

module testbench;
    import lmsf_pkg::*;

    // One command word as it travels on the slave side
    typedef struct packed {
        logic            drain;   // wait until every due beat has arrived before offering
        t_op             op;
        logic [ROW_W-1:0] row;
        logic [CIN_W-1:0] col;
        logic [RGB_W-1:0] color;
    } t_panel_cmd;

    // One output beat as predicted and as observed
    typedef struct packed {
        t_kind              kind;
        logic [ENTRY_W-1:0] bits;
        logic [SEC_W-1:0]   addr;
        logic               blanked;
        logic               last;
    } t_panel_beat;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    led_matrix_scan_framebuffer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_panel_cmd  cmd_backlog[$];
    t_panel_beat panel_beats_due[$];
    int          mismatches = 0;

    // Shadow panel state: both planes, front pointer, scan section, blank flag
    logic [ENTRY_W-1:0] shadow_store [2][PLANE];
    logic               shadow_front;
    logic [SEC_W-1:0]   shadow_section;
    logic               shadow_blanked;

    function automatic t_panel_cmd make_cmd(t_op op, int row, int col, int color,
                                            bit drain = 1'b0);
        t_panel_cmd c;
        c.drain = drain;
        c.op    = op;
        c.row   = row[ROW_W-1:0];
        c.col   = col[CIN_W-1:0];
        c.color = color[RGB_W-1:0];
        return c;
    endfunction

    // Mostly short waits, at least a third of the time none at all
    function automatic int draw_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Apply one command to the shadow panel and queue the beats it causes
    task automatic predict_panel_beats(input t_panel_cmd c);
        logic [SEC_W-1:0]    sec;
        logic                upper;
        logic                back;
        logic [PLANE_AW-1:0] idx;
        logic [ENTRY_W-1:0]  e;
        t_panel_beat         b;
        sec   = c.row[SEC_W-1:0];
        upper = c.row[ROW_W-1];
        back  = ~shadow_front;
        idx   = {sec, c.col};
        case (c.op)
            OP_WRITE: begin
                if (c.col < COLUMNS) begin
                    e = shadow_store[back][idx];
                    if (upper)
                        e[ENTRY_W-1:RGB_W] = c.color;
                    else
                        e[RGB_W-1:0] = c.color;
                    shadow_store[back][idx] = e;
                end
            end
            OP_READ: begin
                e = (c.col < COLUMNS) ? shadow_store[back][idx] : '0;
                b.kind    = KIND_READ;
                b.bits    = upper ? {3'b000, e[ENTRY_W-1:RGB_W]} : {3'b000, e[RGB_W-1:0]};
                b.addr    = '0;
                b.blanked = shadow_blanked;
                b.last    = 1'b1;
                panel_beats_due.push_back(b);
            end
            OP_FILL: begin
                for (int i = 0; i < PLANE; i++)
                    shadow_store[back][i] = {c.color, c.color};
            end
            OP_SWAP: shadow_front = ~shadow_front;
            OP_COPY: begin
                for (int i = 0; i < PLANE; i++)
                    shadow_store[back][i] = shadow_store[shadow_front][i];
            end
            OP_REFRESH: begin
                // Shift beats carry the blank flag from before the tick
                for (int i = 0; i < COLUMNS; i++) begin
                    b.kind    = KIND_SHIFT;
                    b.bits    = shadow_store[shadow_front][{shadow_section, i[COL_W-1:0]}];
                    b.addr    = shadow_section;
                    b.blanked = shadow_blanked;
                    b.last    = 1'b0;
                    panel_beats_due.push_back(b);
                end
                shadow_blanked = 1'b0;
                b.kind    = KIND_LATCH;
                b.bits    = '0;
                b.addr    = shadow_section;
                b.blanked = 1'b0;
                b.last    = 1'b1;
                panel_beats_due.push_back(b);
                shadow_section = shadow_section + 1'b1;
            end
            default: begin
                shadow_blanked = (c.op == OP_BLANK);
                b.kind    = KIND_STATUS;
                b.bits    = '0;
                b.addr    = '0;
                b.blanked = shadow_blanked;
                b.last    = 1'b1;
                panel_beats_due.push_back(b);
            end
        endcase
    endtask

    // Command driver: offer backlog items, idle between them, predict on accept
    t_panel_cmd cmd_on_bus;
    bit         cmd_offered = 1'b0;
    int         sender_wait = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_offered = 1'b0;
            sender_wait = 0;
            s_tvalid <= 1'b0;
        end else begin
            if (cmd_offered && s_tready) begin
                predict_panel_beats(cmd_on_bus);
                cmd_offered = 1'b0;
                sender_wait = draw_gap();
            end
            if (!cmd_offered) begin
                if (sender_wait > 0) begin
                    sender_wait--;
                end else if (cmd_backlog.size() != 0 &&
                             (!cmd_backlog[0].drain || panel_beats_due.size() == 0)) begin
                    cmd_on_bus  = cmd_backlog.pop_front();
                    cmd_offered = 1'b1;
                    s_tdata <= {1'b0, cmd_on_bus.color, cmd_on_bus.col,
                                cmd_on_bus.row, cmd_on_bus.op};
                end
            end
            s_tvalid <= cmd_offered;
        end
    end

    // Beat monitor: compare each accepted beat, stall at random, hold off twice at length
    bit          rx_ready = 1'b0;
    int          rx_wait = 0;
    int          beats_seen = 0;
    t_panel_beat seen_beat;
    t_panel_beat due_beat;

    always @(posedge clk) begin
        if (!rst_n) begin
            rx_ready = 1'b0;
            rx_wait  = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && rx_ready) begin
                seen_beat.kind    = t_kind'(m_tuser);
                seen_beat.bits    = m_tdata[5:0];
                seen_beat.addr    = m_tdata[8:6];
                seen_beat.blanked = m_tdata[9];
                seen_beat.last    = m_tlast;
                if (panel_beats_due.size() == 0) begin
                    $display("%0t: unexpected beat, actual %h", $time, seen_beat);
                    mismatches++;
                end else begin
                    due_beat = panel_beats_due.pop_front();
                    if (seen_beat !== due_beat) begin
                        $display("%0t: mismatch expected %h, actual %h",
                                 $time, due_beat, seen_beat);
                        mismatches++;
                    end
                end
                beats_seen++;
                rx_wait = (beats_seen == 150 || beats_seen == 450) ? 400 : draw_gap();
                rx_ready = (rx_wait == 0);
            end else if (!rx_ready) begin
                if (rx_wait > 0)
                    rx_wait--;
                if (rx_wait == 0)
                    rx_ready = 1'b1;
            end
            m_tready <= rx_ready;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int pick;
        int row;
        int col;
        t_op op;

        for (int i = 0; i < PLANE; i++) begin
            shadow_store[0][i] = '0;
            shadow_store[1][i] = '0;
        end
        shadow_front   = 1'b0;
        shadow_section = '0;
        shadow_blanked = 1'b1;

        // Directed: corners, upper/lower halves of one entry, every operation
        cmd_backlog.push_back(make_cmd(OP_WRITE, 0, 0, 7));
        cmd_backlog.push_back(make_cmd(OP_WRITE, 15, 31, 7));
        cmd_backlog.push_back(make_cmd(OP_WRITE, 8, 0, 5));
        cmd_backlog.push_back(make_cmd(OP_READ, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_READ, 8, 0, 7));
        cmd_backlog.push_back(make_cmd(OP_READ, 15, 31, 0));
        cmd_backlog.push_back(make_cmd(OP_READ, 7, 31, 0));
        cmd_backlog.push_back(make_cmd(OP_REFRESH, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_SWAP, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_REFRESH, 15, 31, 7));
        cmd_backlog.push_back(make_cmd(OP_COPY, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_READ, 8, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_FILL, 0, 0, 2));
        cmd_backlog.push_back(make_cmd(OP_READ, 3, 17, 0));
        cmd_backlog.push_back(make_cmd(OP_BLANK, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_REFRESH, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_UNBLANK, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_SWAP, 0, 0, 0));
        // Walk the remaining sections so the counter wraps
        for (int i = 0; i < 6; i++)
            cmd_backlog.push_back(make_cmd(OP_REFRESH, 0, 0, 0));

        // Random: pixel traffic dominates, half of it packed into a few columns
        for (int i = 0; i < 200; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = OP_WRITE;
            else if (pick < 60) op = OP_READ;
            else if (pick < 64) op = OP_FILL;
            else if (pick < 72) op = OP_SWAP;
            else if (pick < 76) op = OP_COPY;
            else if (pick < 88) op = OP_REFRESH;
            else if (pick < 94) op = OP_BLANK;
            else                op = OP_UNBLANK;
            row = $urandom_range(0, 15);
            col = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31);
            cmd_backlog.push_back(make_cmd(op, row, col, $urandom_range(0, 7),
                                           (i == 0 || i == 100)));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || s_tvalid) @(posedge clk);
        while (panel_beats_due.size() != 0) @(posedge clk);
        // Let a trailing fill or copy finish before calling it done
        repeat (300) @(posedge clk);

        if (mismatches == 0 && panel_beats_due.size() == 0)
            $display("** led_matrix_scan_framebuffer: PASSED **");
        else
            $display("** led_matrix_scan_framebuffer: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("** led_matrix_scan_framebuffer: FAILED **");
        $finish;
    end

endmodule
